/* rtl/core/bsp_pkg.sv */
// Shared types, action codes, flag constants and time packet table of the stream port.
package bsp_pkg;

  // Bus access selector, carried on the slave-side tuser.
  typedef enum logic [3:0] {
    ACT_PFX_COUNT  = 4'd0,
    ACT_PFX_READ   = 4'd1,
    ACT_DATA_READ  = 4'd2,
    ACT_STATUS     = 4'd3,
    ACT_STATUS_CLR = 4'd4,
    ACT_CHAN_READ  = 4'd5,
    ACT_CHAN_LO    = 4'd6,
    ACT_CHAN_HI    = 4'd7,
    ACT_PFX_LATCH  = 4'd8,
    ACT_DATA_LATCH = 4'd9
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

  localparam int ACTION_W   = 4;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 32;
  localparam int CHAN_W     = 14;
  localparam int CAL_W      = 45;
  localparam int OFF_W      = 12;

  localparam logic [7:0] FLAG_LAST  = 8'h80;
  localparam logic [7:0] FLAG_FIRST = 8'h10;
  localparam logic [7:0] FLAG_FAIL  = 8'h0F;
  localparam logic [7:0] CHAN_LO_ALL = 8'hFF;

  // Byte of the time packet at a given offset, from the latched calendar word.
  function automatic logic [7:0] time_byte(input logic [OFF_W-1:0] off,
                                           input logic [CAL_W-1:0] cal);
    logic [15:0] year;
    logic [7:0]  b;
    year = cal[44:29];
    unique case (off)
      12'd4:   b = 8'h10;
      12'd5:   b = 8'h01;
      12'd6:   b = 8'h01;
      12'd10:  b = {2'b00, cal[5:0]};
      12'd11:  b = {2'b00, cal[11:6]};
      12'd12:  b = {3'b000, cal[16:12]};
      12'd13:  b = {5'b00000, cal[19:17]};
      12'd14:  b = {3'b000, cal[24:20]};
      12'd15:  b = {4'b0000, cal[28:25]};
      12'd16:  b = year[7:0];
      12'd17:  b = year[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/broadcast_stream_port_unit.sv */
// Top level of the broadcast stream register port: controller plus datapath.
//
// One slave beat is one bus access to the port. s_tuser carries the access
// code (prefix count, prefix, data, status, status clear, channel read,
// channel low/high write, prefix latch, data latch); s_tdata carries the
// write byte, the host stream lookup answers, the next stream byte and the
// calendar word. One master beat comes back for every access: the read
// byte, a stream-opened flag with its channel and file index, and a flag
// that the offered stream byte was consumed.
// A captured access is executed once the result register is free, and its
// result is then presented on m_tvalid. The port holds one access at a
// time, so it takes no new beat until the last is executed: it captures
// the access, then updates the port state and loads the result register.
// Reset (rst, synchronous, active high) clears the channel, latches,
// queues, offsets and status; m_tvalid drops.
// When the receiver stalls, the result beat holds in its register. One
// further access is still captured, and then waits in execution until the
// pending result is taken, so no beat is lost or reordered.
module broadcast_stream_port_unit
  import bsp_pkg::*;
#(
  parameter int PACKET_BYTES = 22,
  parameter int QUEUE_LIMIT  = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] value, [8] found_at_index, [24:9] packets_at_index,
  // [25] found_at_zero, [41:26] packets_at_zero, [49:42] stream_byte,
  // [94:50] calendar, [95] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [3:0] action
  input  logic [ACTION_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] read_data, [8] loaded, [22:9] loaded_channel,
  // [30:23] loaded_index, [31] byte_taken
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence capture and execution of each access
  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold port state and the result beat
  bsp_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .QUEUE_LIMIT  (QUEUE_LIMIT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* rtl/core/bsp_ctrl.sv */
// Controller state machine: sequences capture and execution of one bus access.
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_EXEC: begin
        cmd.execute = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/bsp_datapath.sv */
// Datapath: access register, port state, update logic and result register.
module bsp_datapath
  import bsp_pkg::*;
#(
  parameter int PACKET_BYTES = 22,
  parameter int QUEUE_LIMIT  = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [ACTION_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int QW   = $clog2(QUEUE_LIMIT + 1);
  localparam int POSW = $clog2(PACKET_BYTES);

  // Captured access
  action_t          act;
  logic [7:0]       value;
  logic             found_idx;
  logic [15:0]      pk_idx;
  logic             found_zero;
  logic [15:0]      pk_zero;
  logic [7:0]       sbyte;
  logic [CAL_W-1:0] cal_in;

  // Port state
  logic [CHAN_W-1:0] chan, chan_next;
  logic [7:0]        pfx, pfx_next;
  logic [7:0]        dat, dat_next;
  logic [7:0]        status, status_next;
  logic              pfx_en, pfx_en_next;
  logic              dat_en, dat_en_next;
  logic              first, first_next;
  logic [OFF_W-1:0]  off, off_next;
  logic [POSW-1:0]   pos, pos_next;
  logic [7:0]        sidx, sidx_next;
  logic [QW-1:0]     pq, pq_next;
  logic [QW-1:0]     dq, dq_next;
  logic              open, open_next;
  logic [CAL_W-1:0]  lcal, lcal_next;

  // Result fields
  logic [7:0]        rd;
  logic              ld;
  logic [CHAN_W-1:0] lch;
  logic [7:0]        lidx;
  logic              taken;

  function automatic logic [QW-1:0] sat_queue(input logic [15:0] cnt);
    return (cnt < 16'(QUEUE_LIMIT)) ? QW'(cnt) : QW'(QUEUE_LIMIT);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act        <= action_t'(s_tuser);
      value      <= s_tdata[7:0];
      found_idx  <= s_tdata[8];
      pk_idx     <= s_tdata[24:9];
      found_zero <= s_tdata[25];
      pk_zero    <= s_tdata[41:26];
      sbyte      <= s_tdata[49:42];
      cal_in     <= s_tdata[94:50];
    end
  end

  always_comb begin
    logic             ok;
    logic [15:0]      cnt;
    logic [7:0]       idx_v;
    logic [7:0]       pb;
    logic [7:0]       db;
    logic [CAL_W-1:0] cal_v;

    chan_next   = chan;
    pfx_next    = pfx;
    dat_next    = dat;
    status_next = status;
    pfx_en_next = pfx_en;
    dat_en_next = dat_en;
    first_next  = first;
    off_next    = off;
    pos_next    = pos;
    sidx_next   = sidx;
    pq_next     = pq;
    dq_next     = dq;
    open_next   = open;
    lcal_next   = lcal;
    rd    = 8'h00;
    ld    = 1'b0;
    lch   = '0;
    lidx  = 8'h00;
    taken = 1'b0;
    ok    = 1'b0;
    cnt   = 16'h0000;
    idx_v = sidx;
    pb    = pfx;
    db    = dat;
    cal_v = lcal;

    unique case (act)
      ACT_PFX_COUNT: begin
        if (pfx_en && dat_en) begin
          if (pq == '0 && dq == '0) begin
            off_next = '0;
            pos_next = '0;
            if (chan == '0) begin
              pq_next    = sat_queue(16'd1);
              dq_next    = sat_queue(16'd1);
              first_next = 1'b1;
            end else begin
              if (found_idx) begin
                ok  = 1'b1;
                cnt = pk_idx;
              end else if (sidx != 8'h00) begin
                idx_v = 8'h00;
                if (found_zero) begin
                  ok  = 1'b1;
                  cnt = pk_zero;
                end
              end
              sidx_next = idx_v;
              if (ok) begin
                ld         = 1'b1;
                lch        = chan;
                lidx       = idx_v;
                open_next  = 1'b1;
                first_next = 1'b1;
                sidx_next  = idx_v + 8'd1;
                pq_next    = sat_queue(cnt);
                dq_next    = sat_queue(cnt);
              end else begin
                open_next = 1'b0;
                pfx_next  = pfx | FLAG_FAIL;
              end
            end
          end
          rd = 8'(pq_next);
        end
      end
      ACT_PFX_READ: begin
        if (pfx_en) begin
          if (pq != '0) begin
            pb = 8'h00;
            if (first) begin
              pb         = pb | FLAG_FIRST;
              first_next = 1'b0;
            end
            pq_next = pq - QW'(1);
            if (pq == QW'(1)) pb = pb | FLAG_LAST;
          end
          pfx_next    = pb;
          status_next = status | pb;
          rd          = pb;
        end
      end
      ACT_DATA_READ: begin
        if (dat_en) begin
          if (dq != '0) begin
            if (chan == '0) begin
              if (off == '0) begin
                cal_v     = cal_in;
                lcal_next = cal_in;
              end
              db = time_byte(off, cal_v);
            end else if (open) begin
              db    = sbyte;
              taken = 1'b1;
            end
            off_next = off + OFF_W'(1);
            // Packet boundary: drop one packet from the data queue
            if (pos == POSW'(PACKET_BYTES - 1)) begin
              pos_next = '0;
              dq_next  = dq - QW'(1);
            end else begin
              pos_next = pos + POSW'(1);
            end
          end
          dat_next = db;
          rd       = db;
        end
      end
      ACT_STATUS: begin
        rd = status;
      end
      ACT_STATUS_CLR: begin
        rd          = status;
        status_next = 8'h00;
      end
      ACT_CHAN_READ: begin
        rd = chan[7:0];
      end
      ACT_CHAN_LO: begin
        if (chan[7:0] != CHAN_LO_ALL) sidx_next = 8'h00;
        chan_next = {chan[13:8], value};
      end
      ACT_CHAN_HI: begin
        if (chan[13:8] != value[5:0]) sidx_next = 8'h00;
        chan_next = {value[5:0], chan[7:0]};
      end
      ACT_PFX_LATCH: begin
        pfx_en_next = (value != 8'h00);
        pq_next     = '0;
      end
      ACT_DATA_LATCH: begin
        dat_en_next = (value != 8'h00);
        dq_next     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan   <= '0;
      pfx    <= 8'h00;
      dat    <= 8'h00;
      status <= 8'h00;
      pfx_en <= 1'b0;
      dat_en <= 1'b0;
      first  <= 1'b0;
      off    <= '0;
      pos    <= '0;
      sidx   <= 8'h00;
      pq     <= '0;
      dq     <= '0;
      open   <= 1'b0;
      lcal   <= '0;
    end else if (cmd.execute) begin
      chan   <= chan_next;
      pfx    <= pfx_next;
      dat    <= dat_next;
      status <= status_next;
      pfx_en <= pfx_en_next;
      dat_en <= dat_en_next;
      first  <= first_next;
      off    <= off_next;
      pos    <= pos_next;
      sidx   <= sidx_next;
      pq     <= pq_next;
      dq     <= dq_next;
      open   <= open_next;
      lcal   <= lcal_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.execute) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      m_tdata <= {taken, lidx, lch, ld, rd};
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

/* bench/stream_port_checker.sv */
// Scoreboard for the stream port: predicts every reply beat from the accesses and compares.
`timescale 1ns / 100ps

module stream_port_checker
  import bsp_pkg::*;
#(
  parameter int PACKET_BYTES = 22,
  parameter int QUEUE_LIMIT  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);

  // Lowest field in the lowest bits, so the last member comes first here.
  typedef struct packed {
    logic        pad;
    logic [44:0] cal;
    logic [7:0]  stream_byte;
    logic [15:0] pk_zero;
    logic        found_zero;
    logic [15:0] pk_idx;
    logic        found_idx;
    logic [7:0]  value;
  } access_t;

  typedef struct packed {
    logic        taken;
    logic [7:0]  lidx;
    logic [13:0] lch;
    logic        loaded;
    logic [7:0]  rd;
  } reply_t;

  // Port state as the block should hold it.
  logic [13:0] chan_num;
  logic [7:0]  pfx_held;
  logic [7:0]  data_held;
  logic [7:0]  status_sticky;
  logic        pfx_on;
  logic        data_on;
  logic        first_due;
  logic [11:0] byte_pos;
  logic [7:0]  file_idx;
  logic [7:0]  pfx_left;
  logic [7:0]  data_left;
  logic        stream_live;
  logic [44:0] cal_held;

  reply_t expected_replies[$];
  reply_t want;
  reply_t got;
  int     errors = 0;

  function automatic logic [7:0] clamp_packets(input logic [15:0] n);
    if (n < QUEUE_LIMIT) return n[7:0];
    return 8'(QUEUE_LIMIT);
  endfunction

  // Time packet layout: fixed header bytes, then the calendar fields.
  function automatic logic [7:0] clock_byte(input logic [11:0] pos, input logic [44:0] cw);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      12'd4:        b = 8'h10;
      12'd5, 12'd6: b = 8'h01;
      12'd10:       b[5:0] = cw[5:0];
      12'd11:       b[5:0] = cw[11:6];
      12'd12:       b[4:0] = cw[16:12];
      12'd13:       b[2:0] = cw[19:17];
      12'd14:       b[4:0] = cw[24:20];
      12'd15:       b[3:0] = cw[28:25];
      12'd16:       b = cw[36:29];
      12'd17:       b = cw[44:37];
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  task automatic apply_access(input logic [3:0] act, input access_t a, output reply_t r);
    logic        ok;
    logic [15:0] cnt;
    r   = '0;
    ok  = 1'b0;
    cnt = '0;
    case (act)
      ACT_PFX_COUNT: begin
        if (pfx_on && data_on) begin
          if (pfx_left == 0 && data_left == 0) begin
            byte_pos = '0;
            if (chan_num == 0) begin
              pfx_left  = clamp_packets(16'd1);
              data_left = clamp_packets(16'd1);
              first_due = 1'b1;
            end else begin
              if (a.found_idx) begin
                ok  = 1'b1;
                cnt = a.pk_idx;
              end else if (file_idx != 0) begin
                file_idx = '0;
                if (a.found_zero) begin
                  ok  = 1'b1;
                  cnt = a.pk_zero;
                end
              end
              if (ok) begin
                r.loaded    = 1'b1;
                r.lch       = chan_num;
                r.lidx      = file_idx;
                stream_live = 1'b1;
                first_due   = 1'b1;
                file_idx    = file_idx + 8'd1;
                pfx_left    = clamp_packets(cnt);
                data_left   = clamp_packets(cnt);
              end else begin
                stream_live = 1'b0;
                pfx_held    = pfx_held | FLAG_FAIL;
              end
            end
          end
          r.rd = pfx_left;
        end
      end
      ACT_PFX_READ: begin
        if (pfx_on) begin
          if (pfx_left > 0) begin
            pfx_held = '0;
            if (first_due) begin
              pfx_held  = pfx_held | FLAG_FIRST;
              first_due = 1'b0;
            end
            pfx_left = pfx_left - 8'd1;
            if (pfx_left == 0) pfx_held = pfx_held | FLAG_LAST;
          end
          status_sticky = status_sticky | pfx_held;
          r.rd = pfx_held;
        end
      end
      ACT_DATA_READ: begin
        if (data_on) begin
          if (data_left > 0) begin
            if (chan_num == 0) begin
              if (byte_pos == 0) cal_held = a.cal;
              data_held = clock_byte(byte_pos, cal_held);
            end else if (stream_live) begin
              data_held = a.stream_byte;
              r.taken   = 1'b1;
            end
            byte_pos = byte_pos + 12'd1;
            if ((int'(byte_pos) % PACKET_BYTES) == 0) data_left = data_left - 8'd1;
          end
          r.rd = data_held;
        end
      end
      ACT_STATUS:     r.rd = status_sticky;
      ACT_STATUS_CLR: begin
        r.rd          = status_sticky;
        status_sticky = '0;
      end
      ACT_CHAN_READ:  r.rd = chan_num[7:0];
      ACT_CHAN_LO: begin
        if (chan_num[7:0] != CHAN_LO_ALL) file_idx = '0;
        chan_num[7:0] = a.value;
      end
      ACT_CHAN_HI: begin
        if (chan_num[13:8] != a.value[5:0]) file_idx = '0;
        chan_num[13:8] = a.value[5:0];
      end
      ACT_PFX_LATCH: begin
        pfx_on   = a.value != 0;
        pfx_left = '0;
      end
      ACT_DATA_LATCH: begin
        data_on   = a.value != 0;
        data_left = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chan_num      <= '0;
      pfx_held      <= '0;
      data_held     <= '0;
      status_sticky <= '0;
      pfx_on        <= 1'b0;
      data_on       <= 1'b0;
      first_due     <= 1'b0;
      byte_pos      <= '0;
      file_idx      <= '0;
      pfx_left      <= '0;
      data_left     <= '0;
      stream_live   <= 1'b0;
      cal_held      <= '0;
      expected_replies.delete();
    end else begin
      // Retire the oldest expectation first; a reply never belongs to this edge's access.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: reply beat with nothing expected, expected none actual %08h",
                   $time, m_tdata);
        end else begin
          want = expected_replies.pop_front();
          check_field("read_data", want.rd, got.rd);
          check_field("loaded", want.loaded, got.loaded);
          check_field("loaded_channel", want.lch, got.lch);
          check_field("loaded_index", want.lidx, got.lidx);
          check_field("byte_taken", want.taken, got.taken);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_access(s_tuser, s_tdata, want);
        expected_replies.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= expected_replies.size();
  end

endmodule

/* bench/tb_broadcast_stream_port_unit.sv */
// Top of the stream port bench: clock, reset, access stimulus, reply back-pressure and verdict.
`timescale 1ns / 100ps

module tb_broadcast_stream_port_unit;
  import bsp_pkg::*;

  localparam int ITEM_TARGET  = 550;
  localparam int LIMIT_CYCLES = 500000;

  // Access codes the port ignores.
  localparam logic [3:0] ACT_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] ACT_LAST_UNUSED  = 4'd15;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [ACTION_W-1:0]   s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int items_sent = 0;   // sender's own count, blocking
  int beats_sent = 0;   // same count for the receiver process, updated at the edge
  int cycles     = 0;
  bit no_gaps    = 1'b0;

  broadcast_stream_port_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stream_port_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Pack the access fields into tdata, lowest field in the lowest bits, top bit zero.
  function automatic logic [95:0] make_access(input logic [7:0] value, input logic fi,
                                              input logic [15:0] pi, input logic fz,
                                              input logic [15:0] pz, input logic [7:0] sb,
                                              input logic [44:0] cal);
    return {1'b0, cal, sb, pz, fz, pi, fi, value};
  endfunction

  // Every field random, the pad bit zero.
  function automatic logic [95:0] noise_access();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return make_access(8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
                       16'($urandom), 8'($urandom), w[44:0]);
  endfunction

  // Mostly tiny packet counts so loads drain; now and then zero, saturating or wild.
  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom % 16;
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom);
    if (r == 2) return 16'($urandom_range(128, 300));
    return 16'($urandom_range(1, 3));
  endfunction

  function automatic logic [7:0] pick_latch();
    if ($urandom % 8 == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  // Idle gaps: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom % 100;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat and hold it until the port takes it. Ends on the accepting edge
  // with tvalid still high, so a back-to-back beat needs no second assignment.
  task automatic send_beat(input logic [3:0] act, input logic [95:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    beats_sent <= beats_sent + 1;
  endtask

  task automatic send_write(input logic [3:0] act, input logic [7:0] v);
    logic [95:0] d;
    d = noise_access();
    d[7:0] = v;
    send_beat(act, d);
  endtask

  // Drop tvalid and hold off until every predicted reply has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A side access dropped into a read run: mostly harmless reads, sometimes a channel write.
  task automatic send_aside();
    case ($urandom % 6)
      0:       send_beat(ACT_STATUS, noise_access());
      1:       send_beat(ACT_STATUS_CLR, noise_access());
      2:       send_beat(ACT_CHAN_READ, noise_access());
      3:       send_beat(4'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)), noise_access());
      4:       send_beat(ACT_PFX_READ, noise_access());
      default: send_write(ACT_CHAN_LO, 8'($urandom));
    endcase
  endtask

  // One well-formed load: optional latch and channel setup, a count read, then
  // prefix and data reads packet by packet, some runs cut short.
  task automatic run_session();
    int          npk;
    int          nbytes;
    logic [63:0] w;
    no_gaps = ($urandom % 4 == 0);
    if ($urandom % 4 == 0) begin
      send_write(ACT_PFX_LATCH, pick_latch());
      send_write(ACT_DATA_LATCH, pick_latch());
    end
    if ($urandom % 2 == 1) begin
      case ($urandom % 5)
        0, 1: begin
          send_write(ACT_CHAN_LO, 8'h00);
          send_write(ACT_CHAN_HI, 8'h00);
        end
        2, 3: begin
          send_write(ACT_CHAN_LO, 8'($urandom_range(1, 255)));
          send_write(ACT_CHAN_HI, 8'h00);
        end
        default: begin
          send_write(ACT_CHAN_HI, 8'($urandom));
          send_write(ACT_CHAN_LO, 8'($urandom));
        end
      endcase
    end else if ($urandom % 4 == 0) begin
      send_write(ACT_CHAN_LO, CHAN_LO_ALL);
    end
    w = {$urandom, $urandom};
    send_beat(ACT_PFX_COUNT, make_access(8'($urandom), ($urandom % 4 != 0), pick_count(),
                                         1'($urandom), pick_count(), 8'($urandom), w[44:0]));
    npk = $urandom_range(0, 2);
    repeat (npk) begin
      send_beat(ACT_PFX_READ, noise_access());
      nbytes = ($urandom % 4 == 0) ? $urandom_range(1, 21) : 22;
      repeat (nbytes) begin
        if ($urandom % 12 == 0) send_aside();
        send_beat(ACT_DATA_READ, noise_access());
      end
    end
  endtask

  task automatic run_noise();
    no_gaps = 1'b0;
    repeat ($urandom_range(3, 10)) send_beat(4'($urandom_range(0, 15)), noise_access());
  endtask

  // Receiver: random stalls with steady stretches, plus one long hold-off early on
  // so the port fills up and stalls its input.
  initial begin : rx_side
    int stall;
    int mode_left;
    int r;
    bit steady;
    bit choked;
    m_tready  = 1'b0;
    stall     = 0;
    mode_left = 0;
    steady    = 1'b0;
    choked    = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        steady    = ($urandom % 3 == 0);
        mode_left = $urandom_range(100, 300);
      end
      mode_left--;
      if (!choked && beats_sent >= 120) begin
        choked = 1'b1;
        stall  = 300;
      end else if (stall == 0 && !steady) begin
        r = $urandom % 100;
        if (r < 70)      stall = 0;
        else if (r < 93) stall = $urandom_range(1, 4);
        else if (r < 99) stall = $urandom_range(5, 20);
        else             stall = $urandom_range(40, 120);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stim
    int random_start;
    bit paused;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tuser      = '0;
    s_tdata      = '0;
    paused       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored code, disabled port, channel extremes, load failure,
    // saturating load, latch off, fallback to index zero with zero packets.
    send_beat(ACT_LAST_UNUSED, {1'b0, {95{1'b1}}});
    send_beat(ACT_STATUS, '0);
    send_beat(ACT_PFX_COUNT, '0);
    send_beat(ACT_PFX_READ, '0);
    send_beat(ACT_DATA_READ, '0);
    send_write(ACT_CHAN_LO, 8'hFF);
    send_write(ACT_CHAN_HI, 8'hFF);
    send_beat(ACT_CHAN_READ, '0);
    send_write(ACT_PFX_LATCH, 8'hFF);
    send_write(ACT_DATA_LATCH, 8'h01);
    send_beat(ACT_PFX_COUNT, make_access(8'h00, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 8'h00, '0));
    send_beat(ACT_PFX_READ, '0);
    send_beat(ACT_STATUS_CLR, '0);
    send_beat(ACT_STATUS, '0);
    send_beat(ACT_PFX_COUNT, make_access(8'hFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 8'h00, '0));
    send_beat(ACT_PFX_READ, '0);
    send_beat(ACT_DATA_READ, make_access(8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000, 8'hFF, '0));
    send_write(ACT_DATA_LATCH, 8'h00);
    send_beat(ACT_DATA_READ, '0);
    send_write(ACT_PFX_LATCH, 8'h80);
    send_write(ACT_DATA_LATCH, 8'h02);
    send_beat(ACT_PFX_COUNT, make_access(8'h00, 1'b0, 16'h0005, 1'b1, 16'h0000, 8'h00, '0));
    send_beat(ACT_PFX_COUNT, make_access(8'h00, 1'b1, 16'h0001, 1'b0, 16'h0000, 8'h00, '0));
    send_beat(ACT_PFX_READ, '0);
    send_write(ACT_CHAN_LO, 8'h00);
    send_write(ACT_CHAN_HI, 8'h00);
    drain_results();

    // Random: mostly well-formed loads, some noise bursts; pause once midway
    // until every reply is back.
    random_start = items_sent;
    while (items_sent - random_start < ITEM_TARGET) begin
      if ($urandom % 5 == 0) run_noise();
      else run_session();
      if (!paused && items_sent - random_start > ITEM_TARGET / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
